// File: sv/nms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nms_pkg
// Shared types and constants of the box non-maximum suppression block.
// ----------------------------------------------------------------------------
package nms_pkg;

   // field widths fixed by the request and result formats
   localparam int COORD_W       = 16;
   localparam int SIZE_W        = 15;
   localparam int CONF_W        = 16;
   localparam int SRC_W         = 6;
   localparam int THR_W         = 16;
   localparam int AREA_W        = 2 * SIZE_W;
   localparam int MAX_BOXES_DEF = 64;

   localparam logic [THR_W-1:0] THRESH_RESET = 16'd26214;

   // one stored box with its suppression mark
   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic [SIZE_W-1:0]         w;
      logic [SIZE_W-1:0]         h;
      logic [CONF_W-1:0]         conf;
      logic [SRC_W-1:0]          src;
      logic                      sup;
   } entry_type;

   // what every cell of the chain does in a cycle
   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_SHIFT  = 2'd2,
      CELL_ROTATE = 2'd3
   } cell_op_type;

   // control broadcast to the chain
   typedef struct packed {
      cell_op_type op;
      entry_type   new_entry;
      entry_type   ring_entry;
   } cell_ctrl_type;

endpackage

// File: sv/nms_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nms_cell
// One slot of the ranked box chain: sorted insert, shift out and rotate.
// ----------------------------------------------------------------------------
module nms_cell
   import nms_pkg::*;
#(
   parameter int INDEX = 0,
   parameter int CNT_W = 7
) (
   input  logic               clock,
   input  cell_ctrl_type      ctrl,
   input  entry_type          left_entry,
   input  entry_type          right_entry,
   input  logic               left_ge,
   input  logic [CNT_W-1:0]   count,
   output entry_type          entry_o,
   output logic               ge_o
);

   entry_type entry_ff;
   entry_type entry_in;
   logic      tail;

   // occupied and ranked at or above the incoming box
   assign ge_o = (CNT_W'(INDEX) < count) && (entry_ff.conf >= ctrl.new_entry.conf);
   assign tail = (CNT_W'(INDEX + 1) == count);

   // next content of the slot
   always_comb begin
      entry_in = entry_ff;
      case (ctrl.op)
         CELL_INSERT: begin
            if (ge_o) begin
               entry_in = entry_ff;
            end else if (left_ge) begin
               entry_in = ctrl.new_entry;
            end else begin
               entry_in = left_entry;
            end
         end
         CELL_SHIFT: begin
            entry_in = right_entry;
         end
         CELL_ROTATE: begin
            entry_in = tail ? ctrl.ring_entry : right_entry;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_o = entry_ff;

endmodule

// File: sv/nms_iou.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nms_iou
// Pipelined overlap test: intersection * 2^16 > threshold * union.
// ----------------------------------------------------------------------------
module nms_iou
   import nms_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  entry_type        a,
   input  entry_type        b,
   input  logic [THR_W-1:0] threshold,
   output logic             done,
   output logic             hit
);

   localparam int EDGE_W = COORD_W + 1;
   localparam int DIFF_W = COORD_W + 2;
   localparam int UNI_W  = AREA_W + 1;
   localparam int PROD_W = UNI_W + THR_W;

   logic [3:0] valid_ff;

   logic signed [COORD_W-1:0] x1_ff, y1_ff;
   logic signed [EDGE_W-1:0]  x2_ff, y2_ff;
   logic [AREA_W-1:0]         area_a_ff, area_b_ff;
   logic [AREA_W-1:0]         inter2_ff, inter3_ff, inter4_ff;
   logic [UNI_W-1:0]          asum_ff, uni3_ff, uni4_ff;
   logic [PROD_W-1:0]         prod_ff;

   logic signed [EDGE_W-1:0]  ax2, bx2, ay2, by2;
   logic signed [DIFF_W-1:0]  dx, dy;
   logic [SIZE_W-1:0]         iw, ih;
   logic [PROD_W-1:0]         inter_scaled;

   // stage 1 edges and areas
   assign ax2 = {a.x[COORD_W-1], a.x} + $signed({2'b00, a.w});
   assign bx2 = {b.x[COORD_W-1], b.x} + $signed({2'b00, b.w});
   assign ay2 = {a.y[COORD_W-1], a.y} + $signed({2'b00, a.h});
   assign by2 = {b.y[COORD_W-1], b.y} + $signed({2'b00, b.h});

   // stage 2 intersection extents, never wider than a box side
   assign dx = {x2_ff[EDGE_W-1], x2_ff} - {{2{x1_ff[COORD_W-1]}}, x1_ff};
   assign dy = {y2_ff[EDGE_W-1], y2_ff} - {{2{y1_ff[COORD_W-1]}}, y1_ff};
   assign iw = (dx > 0) ? dx[SIZE_W-1:0] : '0;
   assign ih = (dy > 0) ? dy[SIZE_W-1:0] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[2:0], start};
      end
   end

   always_ff @(posedge clock) begin
      x1_ff     <= (a.x > b.x) ? a.x : b.x;
      y1_ff     <= (a.y > b.y) ? a.y : b.y;
      x2_ff     <= (ax2 < bx2) ? ax2 : bx2;
      y2_ff     <= (ay2 < by2) ? ay2 : by2;
      area_a_ff <= a.w * a.h;
      area_b_ff <= b.w * b.h;
      inter2_ff <= iw * ih;
      asum_ff   <= {1'b0, area_a_ff} + {1'b0, area_b_ff};
      uni3_ff   <= asum_ff - {1'b0, inter2_ff};
      inter3_ff <= inter2_ff;
      prod_ff   <= {{(PROD_W-UNI_W){1'b0}}, uni3_ff} * {{(PROD_W-THR_W){1'b0}}, threshold};
      uni4_ff   <= uni3_ff;
      inter4_ff <= inter3_ff;
   end

   // final compare, a zero union never suppresses
   assign inter_scaled = {{(PROD_W-AREA_W-16){1'b0}}, inter4_ff, 16'h0000};
   assign hit  = (uni4_ff != '0) && (inter_scaled > prod_ff);
   assign done = valid_ff[3];

endmodule

// File: sv/box_non_maximum_suppression.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_non_maximum_suppression
// Greedy IoU non-maximum suppression over one frame of detection boxes.
// ----------------------------------------------------------------------------
// Each request is taken while busy is low; a present request is inserted
// at once into a chain of MAX_BOXES cells kept sorted by descending
// confidence (ties keep arrival order), and is dropped when the chain is
// full. A request with frame_last raises busy until the frame is done.
// Suppression walks the chain: the head box is popped; when kept, the rest
// of the chain rotates past one shared pipelined IoU unit, and suppressed
// boxes pass without an overlap test. Results come out on a one-cycle
// rsp_strobe, one per kept box, the last with rsp_result_last; a frame
// with no box gives one result with rsp_kept_valid low. The receiver
// cannot stall the block.
// ----------------------------------------------------------------------------
module box_non_maximum_suppression
   import nms_pkg::*;
#(
   parameter int MAX_BOXES = MAX_BOXES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic signed [COORD_W-1:0] req_box_x,
   input  logic signed [COORD_W-1:0] req_box_y,
   input  logic [SIZE_W-1:0]         req_box_width,
   input  logic [SIZE_W-1:0]         req_box_height,
   input  logic [CONF_W-1:0]         req_box_confidence,
   input  logic                      req_box_present,
   input  logic                      req_frame_last,
   input  logic                      csr_wr_en,
   input  logic [THR_W-1:0]          csr_wr_data,
   output logic                      rsp_strobe,
   output logic signed [COORD_W-1:0] rsp_kept_x,
   output logic signed [COORD_W-1:0] rsp_kept_y,
   output logic [SIZE_W-1:0]         rsp_kept_width,
   output logic [SIZE_W-1:0]         rsp_kept_height,
   output logic [CONF_W-1:0]         rsp_kept_confidence,
   output logic [SRC_W-1:0]          rsp_kept_source,
   output logic                      rsp_kept_valid,
   output logic                      rsp_dropped_overflow,
   output logic                      rsp_result_last
);

   localparam int CNT_W = $clog2(MAX_BOXES + 1);

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_SELECT  = 4'b0010,
      ST_COMPARE = 4'b0100,
      ST_WAIT    = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] left_ff, left_in;
   logic             overflow_ff, overflow_in;
   logic [THR_W-1:0] thr_ff;
   entry_type        kept_ff, kept_in;
   entry_type        pend_ff, pend_in;
   logic             pend_valid_ff, pend_valid_in;

   logic             rsp_strobe_ff, rsp_valid_ff, rsp_ovf_ff, rsp_last_ff;
   entry_type        rsp_entry_ff;

   cell_ctrl_type    ctrl;
   entry_type        cell_q [MAX_BOXES];
   logic [MAX_BOXES-1:0] cell_ge;
   entry_type        head;

   logic             accept;
   logic             iou_start, iou_done, iou_hit;
   logic             emit, emit_valid, emit_last;
   entry_type        emit_entry;

   assign head   = cell_q[0];
   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   // chain of ranked cells
   for (genvar i = 0; i < MAX_BOXES; i++) begin : g_cell
      entry_type left_e, right_e;
      logic      left_g;
      if (i == 0) begin : g_first
         assign left_e = ctrl.new_entry;
         assign left_g = 1'b1;
      end else begin : g_mid
         assign left_e = cell_q[i-1];
         assign left_g = cell_ge[i-1];
      end
      if (i == MAX_BOXES - 1) begin : g_last
         assign right_e = cell_q[i];
      end else begin : g_inner
         assign right_e = cell_q[i+1];
      end
      nms_cell #(
         .INDEX (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .left_entry  (left_e),
         .right_entry (right_e),
         .left_ge     (left_g),
         .count       (count_ff),
         .entry_o     (cell_q[i]),
         .ge_o        (cell_ge[i])
      );
   end

   // shared overlap unit
   nms_iou u_iou (
      .clock     (clock),
      .reset     (reset),
      .start     (iou_start),
      .a         (kept_ff),
      .b         (head),
      .threshold (thr_ff),
      .done      (iou_done),
      .hit       (iou_hit)
   );

   // sequencer
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      left_in       = left_ff;
      overflow_in   = overflow_ff;
      kept_in       = kept_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      iou_start     = 1'b0;
      emit          = 1'b0;
      emit_valid    = 1'b1;
      emit_last     = 1'b0;
      emit_entry    = pend_ff;

      ctrl.op                   = CELL_HOLD;
      ctrl.new_entry.x          = req_box_x;
      ctrl.new_entry.y          = req_box_y;
      ctrl.new_entry.w          = req_box_width;
      ctrl.new_entry.h          = req_box_height;
      ctrl.new_entry.conf       = req_box_confidence;
      ctrl.new_entry.src        = SRC_W'(count_ff);
      ctrl.new_entry.sup        = 1'b0;
      ctrl.ring_entry           = head;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_box_present) begin
                  if (count_ff < CNT_W'(MAX_BOXES)) begin
                     ctrl.op  = CELL_INSERT;
                     count_in = count_ff + 1'b1;
                  end else begin
                     overflow_in = 1'b1;
                  end
               end
               if (req_frame_last) begin
                  state_in = ST_SELECT;
               end
            end
         end
         ST_SELECT: begin
            if (count_ff == '0) begin
               // frame done: flush the held result as the last one
               emit          = 1'b1;
               emit_last     = 1'b1;
               emit_valid    = pend_valid_ff;
               emit_entry    = pend_valid_ff ? pend_ff : '0;
               overflow_in   = 1'b0;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end else begin
               ctrl.op  = CELL_SHIFT;
               count_in = count_ff - 1'b1;
               if (!head.sup) begin
                  emit          = pend_valid_ff;
                  pend_in       = head;
                  pend_valid_in = 1'b1;
                  kept_in       = head;
                  left_in       = count_ff - 1'b1;
                  if (count_ff != CNT_W'(1)) begin
                     state_in = ST_COMPARE;
                  end
               end
            end
         end
         ST_COMPARE: begin
            if (head.sup) begin
               ctrl.op = CELL_ROTATE;
               left_in = left_ff - 1'b1;
               if (left_ff == CNT_W'(1)) begin
                  state_in = ST_SELECT;
               end
            end else begin
               iou_start = 1'b1;
               state_in  = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (iou_done) begin
               ctrl.op             = CELL_ROTATE;
               ctrl.ring_entry.sup = iou_hit;
               left_in             = left_ff - 1'b1;
               state_in = (left_ff == CNT_W'(1)) ? ST_SELECT : ST_COMPARE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         left_ff       <= '0;
         overflow_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         thr_ff        <= THRESH_RESET;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         left_ff       <= left_in;
         overflow_ff   <= overflow_in;
         pend_valid_ff <= pend_valid_in;
         rsp_strobe_ff <= emit;
         if (csr_wr_en) begin
            thr_ff <= csr_wr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      kept_ff <= kept_in;
      pend_ff <= pend_in;
      if (emit) begin
         rsp_entry_ff <= emit_entry;
         rsp_valid_ff <= emit_valid;
         rsp_ovf_ff   <= overflow_ff;
         rsp_last_ff  <= emit_last;
      end
   end

   assign rsp_strobe           = rsp_strobe_ff;
   assign rsp_kept_x           = rsp_entry_ff.x;
   assign rsp_kept_y           = rsp_entry_ff.y;
   assign rsp_kept_width       = rsp_entry_ff.w;
   assign rsp_kept_height      = rsp_entry_ff.h;
   assign rsp_kept_confidence  = rsp_entry_ff.conf;
   assign rsp_kept_source      = rsp_entry_ff.src;
   assign rsp_kept_valid       = rsp_valid_ff;
   assign rsp_dropped_overflow = rsp_ovf_ff;
   assign rsp_result_last      = rsp_last_ff;

   // checks
   a_rsp_from_select: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(state_ff == ST_SELECT))
      else $error("result without a select step");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_last_ff) |-> (state_ff == ST_IDLE))
      else $error("last result while still busy");

   a_iou_in_wait: assert property (@(posedge clock) disable iff (reset)
      iou_done |-> (state_ff == ST_WAIT))
      else $error("overlap result outside wait");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      (count_ff <= CNT_W'(MAX_BOXES)) && (left_ff <= count_ff))
      else $error("box count out of range");

endmodule
